### hdl/max_heap_priority_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit_macros.svh
// Assertion macros used by the priority queue datapath. Define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// a implies b in the same cycle
`define MHPQ_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: implication");

// a implies b in the next cycle
`define MHPQ_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");

// a never holds
`define MHPQ_ASSERT_NEVER(label, clk, rst, a) \
   label: assert property (@(posedge clk) disable iff (rst) !(a)) \
      else $error("assertion failed: forbidden condition");

`else

`define MHPQ_ASSERT_IMPLIES(label, clk, rst, a, b)
`define MHPQ_ASSERT_NEXT(label, clk, rst, a, b)
`define MHPQ_ASSERT_NEVER(label, clk, rst, a)

`endif

`endif

### hdl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types, codes and helpers shared by the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

   // sizing
   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int IDX_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int REQ_W    = 2;
   localparam int STAT_W   = 3;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_EXTRACT  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_INCREASE = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_SMALLER = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BADIDX  = 3'd4;

   // request word
   typedef struct packed {
      logic [REQ_W-1:0]        req_type;
      logic signed [KEY_W-1:0] key_value;
      logic [IDX_W-1:0]        entry_index;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic signed [KEY_W-1:0] max_key;
      logic [IDX_W-1:0]        entry_count;
   } rsp_word_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_EX_LOAD,
      S_INC_CHK,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic              accept;
      logic              set_status;
      logic [STAT_W-1:0] status_code;
      logic              ins_start;
      logic              ex_read;
      logic              ex_load;
      logic              inc_read;
      logic              inc_start;
      logic              up_read;
      logic              up_move;
      logic              dn_read;
      logic              dn_move;
      logic              write_cur;
      logic              load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             full;
      logic             empty;
      logic             bad_idx;
      logic             smaller;
      logic             pos_is_root;
      logic             up_swap;
      logic             dn_leaf;
      logic             dn_swap;
      logic             rsp_free;
   } stat_type;

   // 1-based heap slot to RAM address
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] slot);
      logic [IDX_W-1:0] tmp;
      tmp = slot - IDX_W'(1);
      return tmp[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

### hdl/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

### hdl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for the heap: decodes a request, walks the sift loop one level
// per read/compare pair and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire mhpq_pkg::stat_type stat,
   output      mhpq_pkg::cmd_type  cmd
);

   mhpq_pkg::state_type state_ff;
   mhpq_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhpq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mhpq_pkg::S_IDLE: begin
            if (req_valid) state_in = mhpq_pkg::S_DECODE;
         end
         mhpq_pkg::S_DECODE: begin
            case (stat.req_type)
               mhpq_pkg::REQ_INSERT:
                  state_in = stat.full ? mhpq_pkg::S_RESP : mhpq_pkg::S_UP_RD;
               mhpq_pkg::REQ_EXTRACT:
                  state_in = stat.empty ? mhpq_pkg::S_RESP : mhpq_pkg::S_EX_LOAD;
               mhpq_pkg::REQ_INCREASE:
                  state_in = stat.bad_idx ? mhpq_pkg::S_RESP : mhpq_pkg::S_INC_CHK;
               default:
                  state_in = mhpq_pkg::S_RESP;
            endcase
         end
         mhpq_pkg::S_EX_LOAD: state_in = mhpq_pkg::S_DN_RD;
         mhpq_pkg::S_INC_CHK: begin
            state_in = stat.smaller ? mhpq_pkg::S_RESP : mhpq_pkg::S_UP_RD;
         end
         mhpq_pkg::S_UP_RD: begin
            state_in = stat.pos_is_root ? mhpq_pkg::S_RESP : mhpq_pkg::S_UP_CMP;
         end
         mhpq_pkg::S_UP_CMP: begin
            state_in = stat.up_swap ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_RESP;
         end
         mhpq_pkg::S_DN_RD: begin
            state_in = stat.dn_leaf ? mhpq_pkg::S_RESP : mhpq_pkg::S_DN_CMP;
         end
         mhpq_pkg::S_DN_CMP: begin
            state_in = stat.dn_swap ? mhpq_pkg::S_DN_RD : mhpq_pkg::S_RESP;
         end
         mhpq_pkg::S_RESP: begin
            if (stat.rsp_free) state_in = mhpq_pkg::S_IDLE;
         end
         default: state_in = mhpq_pkg::S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != mhpq_pkg::S_IDLE);
      case (state_ff)
         mhpq_pkg::S_IDLE: begin
            cmd.accept = req_valid;
         end
         mhpq_pkg::S_DECODE: begin
            case (stat.req_type)
               mhpq_pkg::REQ_INSERT: begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = mhpq_pkg::STAT_FULL;
                  end else begin
                     cmd.ins_start = 1'b1;
                  end
               end
               mhpq_pkg::REQ_EXTRACT: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = mhpq_pkg::STAT_EMPTY;
                  end else begin
                     cmd.ex_read = 1'b1;
                  end
               end
               mhpq_pkg::REQ_INCREASE: begin
                  if (stat.bad_idx) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = mhpq_pkg::STAT_BADIDX;
                  end else begin
                     cmd.inc_read = 1'b1;
                  end
               end
               default: begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = mhpq_pkg::STAT_BADIDX;
               end
            endcase
         end
         mhpq_pkg::S_EX_LOAD: begin
            cmd.ex_load = 1'b1;
         end
         mhpq_pkg::S_INC_CHK: begin
            if (stat.smaller) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = mhpq_pkg::STAT_SMALLER;
            end else begin
               cmd.inc_start = 1'b1;
            end
         end
         mhpq_pkg::S_UP_RD: begin
            if (stat.pos_is_root) cmd.write_cur = 1'b1;
            else                  cmd.up_read   = 1'b1;
         end
         mhpq_pkg::S_UP_CMP: begin
            if (stat.up_swap) cmd.up_move   = 1'b1;
            else              cmd.write_cur = 1'b1;
         end
         mhpq_pkg::S_DN_RD: begin
            if (stat.dn_leaf) cmd.write_cur = 1'b1;
            else              cmd.dn_read   = 1'b1;
         end
         mhpq_pkg::S_DN_CMP: begin
            if (stat.dn_swap) cmd.dn_move   = 1'b1;
            else              cmd.write_cur = 1'b1;
         end
         mhpq_pkg::S_RESP: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/mhpq_dpath.sv
// ----------------------------------------------------------------------------
// mhpq_dpath
// Heap datapath: request and result registers, entry count, sift position,
// the key being moved, the heap RAM and the compares that steer the sift.
// ----------------------------------------------------------------------------
`default_nettype none
`include "max_heap_priority_queue_unit_macros.svh"

module mhpq_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mhpq_pkg::req_word_type req_word,
   input  wire logic                   rsp_stall,
   output      logic                   rsp_valid,
   output      mhpq_pkg::rsp_word_type rsp_word,
   input  wire mhpq_pkg::cmd_type      cmd,
   output      mhpq_pkg::stat_type     stat
);

   localparam int IDX_W  = mhpq_pkg::IDX_W;
   localparam int KEY_W  = mhpq_pkg::KEY_W;
   localparam int ADDR_W = mhpq_pkg::ADDR_W;

   mhpq_pkg::req_word_type      req_ff;
   mhpq_pkg::rsp_word_type      rsp_ff;
   logic                        rsp_valid_ff;
   logic [IDX_W-1:0]            count_ff;
   logic [IDX_W-1:0]            pos_ff;
   logic signed [KEY_W-1:0]     cur_ff;
   logic signed [KEY_W-1:0]     maxk_ff;
   logic [mhpq_pkg::STAT_W-1:0] status_ff;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [KEY_W-1:0]        wr_data;
   logic [ADDR_W-1:0]       rd_addr_a;
   logic [ADDR_W-1:0]       rd_addr_b;
   logic [KEY_W-1:0]        rd_data_a;
   logic [KEY_W-1:0]        rd_data_b;
   logic signed [KEY_W-1:0] rd_a;
   logic signed [KEY_W-1:0] rd_b;

   logic [IDX_W-1:0]        parent_slot;
   logic [IDX_W-1:0]        left_slot;
   logic [IDX_W-1:0]        right_slot;
   logic [IDX_W:0]          left_wide;
   logic [IDX_W:0]          right_wide;
   logic [IDX_W-1:0]        count_inc;
   logic                    l_gt;
   logic                    r_ok;
   logic                    r_gt;
   logic                    take_r;
   logic signed [KEY_W-1:0] best_val;
   logic [IDX_W-1:0]        best_slot;

   assign rd_a = $signed(rd_data_a);
   assign rd_b = $signed(rd_data_b);

   // heap neighbors of the current slot
   assign parent_slot = pos_ff >> 1;
   assign left_slot   = {pos_ff[IDX_W-2:0], 1'b0};
   assign right_slot  = {pos_ff[IDX_W-2:0], 1'b1};
   assign left_wide   = {pos_ff, 1'b0};
   assign right_wide  = {pos_ff, 1'b1};
   assign count_inc   = count_ff + IDX_W'(1);

   // sift-down choice: hole holds cur_ff, ties keep the parent
   assign l_gt      = rd_a > cur_ff;
   assign r_ok      = right_wide <= {1'b0, count_ff};
   assign r_gt      = rd_b > (l_gt ? rd_a : cur_ff);
   assign take_r    = r_ok && r_gt;
   assign best_val  = take_r ? rd_b : rd_a;
   assign best_slot = take_r ? right_slot : left_slot;

   // status back to the controller
   always_comb begin
      stat             = '0;
      stat.req_type    = req_ff.req_type;
      stat.full        = (count_ff == IDX_W'(mhpq_pkg::CAPACITY));
      stat.empty       = (count_ff == '0);
      stat.bad_idx     = (req_ff.entry_index == '0) || (req_ff.entry_index > count_ff);
      stat.smaller     = rd_a > req_ff.key_value;
      stat.pos_is_root = (pos_ff == IDX_W'(1));
      stat.up_swap     = cur_ff > rd_a;
      stat.dn_leaf     = left_wide > {1'b0, count_ff};
      stat.dn_swap     = l_gt || take_r;
      stat.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   // RAM read address select
   always_comb begin
      rd_addr_a = '0;
      rd_addr_b = '0;
      if (cmd.ex_read) begin
         rd_addr_a = mhpq_pkg::slot_addr(IDX_W'(1));
         rd_addr_b = mhpq_pkg::slot_addr(count_ff);
      end else if (cmd.inc_read) begin
         rd_addr_a = mhpq_pkg::slot_addr(req_ff.entry_index);
      end else if (cmd.up_read) begin
         rd_addr_a = mhpq_pkg::slot_addr(parent_slot);
      end else if (cmd.dn_read) begin
         rd_addr_a = mhpq_pkg::slot_addr(left_slot);
         rd_addr_b = mhpq_pkg::slot_addr(right_slot);
      end
   end

   // RAM write select: the hole at pos_ff gets the moving key or a neighbor
   always_comb begin
      wr_en   = cmd.write_cur || cmd.up_move || cmd.dn_move;
      wr_addr = mhpq_pkg::slot_addr(pos_ff);
      wr_data = cur_ff;
      if (cmd.up_move)      wr_data = rd_a;
      else if (cmd.dn_move) wr_data = best_val;
   end

   mhpq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (mhpq_pkg::CAPACITY)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.ins_start) begin
         count_ff <= count_inc;
      end else if (cmd.ex_load) begin
         count_ff <= count_ff - IDX_W'(1);
      end
   end

   // request, sift position, moving key, result fields
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff    <= req_word;
         status_ff <= mhpq_pkg::STAT_OK;
         maxk_ff   <= '0;
      end
      if (cmd.set_status) status_ff <= cmd.status_code;
      if (cmd.ins_start) begin
         pos_ff <= count_inc;
         cur_ff <= req_ff.key_value;
      end
      if (cmd.ex_load) begin
         maxk_ff <= rd_a;
         cur_ff  <= rd_b;
         pos_ff  <= IDX_W'(1);
      end
      if (cmd.inc_start) begin
         pos_ff <= req_ff.entry_index;
         cur_ff <= req_ff.key_value;
      end
      if (cmd.up_move) pos_ff <= parent_slot;
      if (cmd.dn_move) pos_ff <= best_slot;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.max_key     <= maxk_ff;
         rsp_ff.entry_count <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   `MHPQ_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > IDX_W'(mhpq_pkg::CAPACITY))
   `MHPQ_ASSERT_IMPLIES(a_write_in_range, clock, reset, wr_en, pos_ff != '0 && pos_ff <= IDX_W'(mhpq_pkg::CAPACITY))
   `MHPQ_ASSERT_IMPLIES(a_err_no_key, clock, reset, rsp_valid_ff && rsp_ff.status != mhpq_pkg::STAT_OK, rsp_ff.max_key == '0)
   `MHPQ_ASSERT_NEXT(a_rsp_loaded, clock, reset, cmd.load_rsp, rsp_valid_ff)

endmodule

`default_nettype wire

### hdl/max_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap priority queue over signed 32-bit keys (insert,
// extract-max, increase-key), one result word per request word.
// ----------------------------------------------------------------------------
// The queue handles one request word at a time and returns exactly one result
// word for it. Keys live in a single heap RAM with registered read data, so
// every heap level a sift walks takes a read state, then a compare-and-write
// state. A request word is turned away at decode when an insert finds the heap
// full, an extract finds it empty, the index is bad or the code is unused; an
// increase-key that carries a smaller key is turned away once its old key has
// been read. Otherwise an insert sifts up, and an increase-key first reads the
// old key and then sifts up. An extract loads the root and the last slot, then
// walks down at most five levels at the default capacity of 64. A finished
// result waits in an output register, and the next request word is taken while
// it is still stalled. Slots are not cleared at reset: the heap only ever uses
// data from slots that it has written.
`default_nettype none

module max_heap_priority_queue_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire mhpq_pkg::req_word_type req_word,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      mhpq_pkg::rsp_word_type rsp_word
);

   mhpq_pkg::cmd_type  cmd;
   mhpq_pkg::stat_type stat;

   // sequencer
   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // heap storage and compares
   mhpq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire
